>>> sv/button_dimmer_controller_macros.svh
// Assertion macros shared by the dimmer controller RTL.
`ifndef BUTTON_DIMMER_CONTROLLER_MACROS_SVH
`define BUTTON_DIMMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bdc_pkg.sv
// Shared types and constants of the button dimmer controller.
package bdc_pkg;

  localparam int DUTY_MAX   = 1023;
  localparam int DUTY_W     = $clog2(DUTY_MAX + 1);
  localparam int PERIOD_W   = 8;
  localparam int HOLD_W     = 6;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int OUT_DUTY_W = 10;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_SCAN_PERIOD   = 2'd0;
  localparam logic [1:0] REG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] REG_HOLD_DELAY    = 2'd2;
  localparam logic [1:0] REG_FLASH_TIME    = 2'd3;

  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST   = 8'd10;
  localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 8'd5;
  localparam logic [HOLD_W-1:0]   HOLD_DELAY_RST    = 6'd45;
  localparam logic [PERIOD_W-1:0] FLASH_TIME_RST    = 8'd100;

  typedef enum logic {
    PHASE_SCAN = 1'b0,
    PHASE_WAIT = 1'b1
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] scan_period;
    logic [PERIOD_W-1:0] repeat_period;
    logic [HOLD_W-1:0]   hold_delay;
    logic [PERIOD_W-1:0] flash_time;
  } cfg_t;

  typedef struct packed {
    logic plus;
    logic minus;
    logic power;
  } buttons_t;

  typedef struct packed {
    logic [OUT_DUTY_W-1:0] duty;
    logic                  pwm_enable;
    logic                  green_led;
    logic                  red_led;
  } result_t;

  // A zero period or flash time acts as one.
  function automatic logic [PERIOD_W-1:0] at_least_one(input logic [PERIOD_W-1:0] v);
    at_least_one = (v == '0) ? PERIOD_W'(1) : v;
  endfunction

endpackage

>>> sv/bdc_cfg.sv
// APB-style configuration register file of the dimmer controller.
module bdc_cfg import bdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period   <= SCAN_PERIOD_RST;
      cfg.repeat_period <= REPEAT_PERIOD_RST;
      cfg.hold_delay    <= HOLD_DELAY_RST;
      cfg.flash_time    <= FLASH_TIME_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SCAN_PERIOD:   cfg.scan_period   <= pwdata[PERIOD_W-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period <= pwdata[PERIOD_W-1:0];
        REG_HOLD_DELAY:    cfg.hold_delay    <= pwdata[HOLD_W-1:0];
        REG_FLASH_TIME:    cfg.flash_time    <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back zero-extended
  always_comb begin
    case (reg_idx)
      REG_SCAN_PERIOD:   prdata = DATA_W'(cfg.scan_period);
      REG_REPEAT_PERIOD: prdata = DATA_W'(cfg.repeat_period);
      REG_HOLD_DELAY:    prdata = DATA_W'(cfg.hold_delay);
      REG_FLASH_TIME:    prdata = DATA_W'(cfg.flash_time);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> sv/bdc_core.sv
// Dimmer state registers and the per-tick update logic.
module bdc_core import bdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     tick,
  input  buttons_t btn,
  input  cfg_t     cfg,
  output result_t  res_next
);

  phase_t              phase, phase_next;
  logic [PERIOD_W-1:0] poll_timer, poll_timer_next;
  logic [HOLD_W-1:0]   hold_count, hold_count_next;
  logic [DUTY_W-1:0]   duty_level, duty_level_next;
  logic                pwm_on, pwm_on_next;
  logic                green_state, green_state_next;
  logic [PERIOD_W-1:0] green_timer, green_timer_next;
  logic                red_state, red_state_next;
  logic [PERIOD_W-1:0] red_timer, red_timer_next;
  logic [PERIOD_W-1:0] toggle_timer, toggle_timer_next;

  logic [PERIOD_W-1:0] scan_ld, repeat_ld, flash_ld;
  logic [HOLD_W:0]     hold_inc;
  logic                do_step;

  assign scan_ld   = at_least_one(cfg.scan_period);
  assign repeat_ld = at_least_one(cfg.repeat_period);
  assign flash_ld  = at_least_one(cfg.flash_time);
  assign hold_inc  = {1'b0, hold_count} + (HOLD_W+1)'(1);

  // Next state for one tick: timers, then the poll task, then the duty step
  always_comb begin
    phase_next        = phase;
    poll_timer_next   = poll_timer;
    hold_count_next   = hold_count;
    duty_level_next   = duty_level;
    pwm_on_next       = pwm_on;
    green_state_next  = green_state;
    green_timer_next  = green_timer;
    red_state_next    = red_state;
    red_timer_next    = red_timer;
    toggle_timer_next = toggle_timer;
    do_step           = 1'b0;

    // Count down the pending timers and fire on expiry
    if (toggle_timer != '0) begin
      toggle_timer_next = toggle_timer - PERIOD_W'(1);
      if (toggle_timer == PERIOD_W'(1)) pwm_on_next = ~pwm_on;
    end
    if (green_timer != '0) begin
      green_timer_next = green_timer - PERIOD_W'(1);
      if (green_timer == PERIOD_W'(1)) green_state_next = 1'b0;
    end
    if (red_timer != '0) begin
      red_timer_next = red_timer - PERIOD_W'(1);
      if (red_timer == PERIOD_W'(1)) red_state_next = 1'b0;
    end

    // Poll task
    if (poll_timer <= PERIOD_W'(1)) begin
      if (phase == PHASE_SCAN) begin
        poll_timer_next = scan_ld;
        if (btn.plus) begin
          green_state_next = 1'b1;
          green_timer_next = flash_ld;
          hold_count_next  = '0;
          do_step          = 1'b1;
          phase_next       = PHASE_WAIT;
        end else if (btn.minus) begin
          red_state_next  = 1'b1;
          red_timer_next  = flash_ld;
          hold_count_next = '0;
          do_step         = 1'b1;
          phase_next      = PHASE_WAIT;
        end else if (btn.power) begin
          toggle_timer_next = scan_ld;
          phase_next        = PHASE_WAIT;
        end
      end else if (btn.plus || btn.minus || btn.power) begin
        poll_timer_next = repeat_ld;
        if (hold_inc > {1'b0, cfg.hold_delay}) begin
          hold_count_next = cfg.hold_delay;
          do_step         = 1'b1;
        end else begin
          hold_count_next = hold_inc[HOLD_W-1:0];
        end
      end else begin
        hold_count_next = '0;
        phase_next      = PHASE_SCAN;
        poll_timer_next = scan_ld;
      end
    end else begin
      poll_timer_next = poll_timer - PERIOD_W'(1);
    end

    // Duty step: plus first, then minus
    if (do_step && btn.plus) begin
      pwm_on_next = 1'b1;
      if (duty_level_next < DUTY_W'(DUTY_MAX)) duty_level_next = duty_level_next + DUTY_W'(1);
      if (duty_level_next == DUTY_W'(DUTY_MAX)) green_state_next = 1'b1;
    end
    if (do_step && btn.minus) begin
      if (duty_level_next != '0) begin
        duty_level_next  = duty_level_next - DUTY_W'(1);
        green_state_next = 1'b0;
      end
      if (duty_level_next == '0) pwm_on_next = 1'b0;
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_SCAN;
      poll_timer   <= '0;
      hold_count   <= '0;
      duty_level   <= '0;
      pwm_on       <= 1'b0;
      green_state  <= 1'b0;
      green_timer  <= '0;
      red_state    <= 1'b0;
      red_timer    <= '0;
      toggle_timer <= '0;
    end else if (tick) begin
      phase        <= phase_next;
      poll_timer   <= poll_timer_next;
      hold_count   <= hold_count_next;
      duty_level   <= duty_level_next;
      pwm_on       <= pwm_on_next;
      green_state  <= green_state_next;
      green_timer  <= green_timer_next;
      red_state    <= red_state_next;
      red_timer    <= red_timer_next;
      toggle_timer <= toggle_timer_next;
    end
  end

  assign res_next.duty       = OUT_DUTY_W'(duty_level_next);
  assign res_next.pwm_enable = pwm_on_next;
  assign res_next.green_led  = green_state_next;
  assign res_next.red_led    = red_state_next;

endmodule

>>> sv/button_dimmer_controller.sv
// An accepted input word is held in the input register; its result is then captured in the result register.
// Throughput: one tick word per cycle while the result side does not stall.
// Input register and result register decouple the two sides, so one new word
// is still taken into an empty input register while a finished result waits.
// Reset (rst, synchronous): scan phase, all timers and duty zero, registers
// back to 10, 5, 45, 100; no clearing pass.
`include "button_dimmer_controller_macros.svh"
module button_dimmer_controller import bdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  plus_pressed,
  input  logic                  minus_pressed,
  input  logic                  power_pressed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DUTY_W-1:0] duty,
  output logic                  pwm_enable,
  output logic                  green_led,
  output logic                  red_led
);

  cfg_t     cfg;
  buttons_t btn;
  logic     btn_valid;
  logic     advance;
  logic     tick;
  result_t  res_next;
  result_t  res;

  assign advance  = !out_valid || out_ready;
  assign tick     = btn_valid && advance;
  assign in_ready = !btn_valid || advance;

  bdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_valid <= 1'b0;
    end else if (in_ready) begin
      btn_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      btn.plus  <= plus_pressed;
      btn.minus <= minus_pressed;
      btn.power <= power_pressed;
    end
  end

  bdc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .btn      (btn),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res       <= '0;
    end else if (advance) begin
      out_valid <= btn_valid;
      if (btn_valid) res <= res_next;
    end
  end

  assign duty       = res.duty;
  assign pwm_enable = res.pwm_enable;
  assign green_led  = res.green_led;
  assign red_led    = res.red_led;

  `BDC_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, btn_valid && out_valid && !out_ready, "input stalled without a blocked result")
  `BDC_ASSERT_NEXT(a_word_held, clk, rst, btn_valid && !advance, btn_valid, "buffered input word dropped while stalled")
  `BDC_ASSERT_NEXT(a_duty_step, clk, rst, tick, duty == $past(duty) || duty == $past(duty) + 10'd1 || duty == $past(duty) - 10'd1, "duty moved by more than one step")

endmodule

>>> tb/sv/button_dimmer_controller_tb.sv
// Self-checking testbench for the button dimmer controller: tick words in, lamp words out.
`timescale 1ns / 100ps

module button_dimmer_controller_tb;
  import bdc_pkg::*;

  // Tracks the lamp state tick by tick and holds the lamp words still owed by the block.
  class lamp_scoreboard;
    logic [PERIOD_W-1:0]   scan_period;
    logic [PERIOD_W-1:0]   repeat_period;
    logic [HOLD_W-1:0]     hold_delay;
    logic [PERIOD_W-1:0]   flash_time;

    phase_t                phase;
    logic [PERIOD_W-1:0]   poll_timer;
    logic [HOLD_W-1:0]     hold_count;
    logic [DUTY_W-1:0]     duty_level;
    bit                    pwm_on;
    bit                    green_on;
    logic [PERIOD_W-1:0]   green_timer;
    bit                    red_on;
    logic [PERIOD_W-1:0]   red_timer;
    logic [PERIOD_W-1:0]   toggle_timer;

    result_t               expected_lamp[$];
    int                    errors;

    function new();
      scan_period   = SCAN_PERIOD_RST;
      repeat_period = REPEAT_PERIOD_RST;
      hold_delay    = HOLD_DELAY_RST;
      flash_time    = FLASH_TIME_RST;
      phase         = PHASE_SCAN;
      poll_timer    = '0;
      hold_count    = '0;
      duty_level    = '0;
      pwm_on        = 1'b0;
      green_on      = 1'b0;
      green_timer   = '0;
      red_on        = 1'b0;
      red_timer     = '0;
      toggle_timer  = '0;
      errors        = 0;
    endfunction

    // Mirror a register write.
    function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_SCAN_PERIOD:   scan_period   = value[PERIOD_W-1:0];
        REG_REPEAT_PERIOD: repeat_period = value[PERIOD_W-1:0];
        REG_HOLD_DELAY:    hold_delay    = value[HOLD_W-1:0];
        REG_FLASH_TIME:    flash_time    = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero in a period or flash register counts as one.
    function logic [PERIOD_W-1:0] nonzero(logic [PERIOD_W-1:0] v);
      return (v == '0) ? PERIOD_W'(1) : v;
    endfunction

    // Apply plus first, then minus.
    function void step_duty(bit up, bit down);
      if (up) begin
        pwm_on = 1'b1;
        if (duty_level < DUTY_W'(DUTY_MAX)) duty_level = duty_level + DUTY_W'(1);
        if (duty_level == DUTY_W'(DUTY_MAX)) green_on = 1'b1;
      end
      if (down) begin
        if (duty_level != '0) begin
          duty_level = duty_level - DUTY_W'(1);
          green_on   = 1'b0;
        end
        if (duty_level == '0) pwm_on = 1'b0;
      end
    endfunction

    // Scan poll: plus or minus flashes its LED and steps once, power arms the toggle; any press starts waiting.
    function void scan_buttons(bit up, bit down, bit pwr);
      if (up) begin
        green_on    = 1'b1;
        green_timer = nonzero(flash_time);
        hold_count  = '0;
        step_duty(up, down);
        phase = PHASE_WAIT;
      end else if (down) begin
        red_on     = 1'b1;
        red_timer  = nonzero(flash_time);
        hold_count = '0;
        step_duty(up, down);
        phase = PHASE_WAIT;
      end else if (pwr) begin
        toggle_timer = nonzero(scan_period);
        phase = PHASE_WAIT;
      end
      poll_timer = nonzero(scan_period);
    endfunction

    // Wait poll: count the hold, repeat the step past the delay, drop back on release.
    function void poll_held(bit up, bit down, bit pwr);
      int held;
      if (up || down || pwr) begin
        held = int'(hold_count) + 1;
        poll_timer = nonzero(repeat_period);
        if (held > int'(hold_delay)) begin
          hold_count = hold_delay;
          step_duty(up, down);
        end else begin
          hold_count = HOLD_W'(held);
        end
      end else begin
        hold_count = '0;
        phase      = PHASE_SCAN;
        poll_timer = nonzero(scan_period);
      end
    endfunction

    // Advance one tick for an accepted word and queue the lamp word it leads to.
    function void take_buttons(buttons_t b);
      result_t want;
      if (toggle_timer != '0) begin
        toggle_timer = toggle_timer - PERIOD_W'(1);
        if (toggle_timer == '0) pwm_on = ~pwm_on;
      end
      if (green_timer != '0) begin
        green_timer = green_timer - PERIOD_W'(1);
        if (green_timer == '0) green_on = 1'b0;
      end
      if (red_timer != '0) begin
        red_timer = red_timer - PERIOD_W'(1);
        if (red_timer == '0) red_on = 1'b0;
      end
      if (poll_timer <= PERIOD_W'(1)) begin
        if (phase == PHASE_SCAN) scan_buttons(b.plus, b.minus, b.power);
        else poll_held(b.plus, b.minus, b.power);
      end else begin
        poll_timer = poll_timer - PERIOD_W'(1);
      end
      want.duty       = OUT_DUTY_W'(duty_level);
      want.pwm_enable = pwm_on;
      want.green_led  = green_on;
      want.red_led    = red_on;
      expected_lamp.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compare an accepted lamp word with the oldest one owed.
    task compare_lamp(result_t got);
      result_t want;
      if (expected_lamp.size() == 0) begin
        report($sformatf("lamp word with no tick pending (duty %0d)", got.duty));
        return;
      end
      want = expected_lamp.pop_front();
      if (got.duty !== want.duty)
        report($sformatf("duty %0d, want %0d", got.duty, want.duty));
      if (got.pwm_enable !== want.pwm_enable)
        report($sformatf("pwm_enable %b, want %b", got.pwm_enable, want.pwm_enable));
      if (got.green_led !== want.green_led)
        report($sformatf("green_led %b, want %b", got.green_led, want.green_led));
      if (got.red_led !== want.red_led)
        report($sformatf("red_led %b, want %b", got.red_led, want.red_led));
    endtask

    function int pending();
      return expected_lamp.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  plus_pressed = 1'b0;
  logic                  minus_pressed = 1'b0;
  logic                  power_pressed = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DUTY_W-1:0] duty;
  logic                  pwm_enable;
  logic                  green_led;
  logic                  red_led;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit holdoff_request = 1'b0;
  bit holdoff_started = 1'b0;
  int holdoff_left    = 0;

  lamp_scoreboard sb = new();

  button_dimmer_controller dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .plus_pressed(plus_pressed), .minus_pressed(minus_pressed),
    .power_pressed(power_pressed),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .pwm_enable(pwm_enable), .green_led(green_led), .red_led(red_led)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random; hold off once for a long stretch on request.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      out_ready <= 1'b0;
    end else if (holdoff_request && !holdoff_started) begin
      holdoff_started = 1'b1;
      holdoff_left    = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Check lamp words and note tick words as they are accepted.
  always @(posedge clk) begin : monitor
    result_t  seen;
    buttons_t taken;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = {duty, pwm_enable, green_led, red_led};
        sb.compare_lamp(seen);
      end
      if (in_valid && in_ready) begin
        taken = {plus_pressed, minus_pressed, power_pressed};
        sb.take_buttons(taken);
      end
    end
  end

  // Offer one tick word, hold it until accepted, then maybe go idle.
  task automatic send_tick(input bit up, input bit down, input bit pwr);
    in_valid      <= 1'b1;
    plus_pressed  <= up;
    minus_pressed <= down;
    power_pressed <= pwr;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // Drop valid, let every owed lamp word arrive, then let the pipe empty.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic write_config(input int scan, input int rep, input int hold, input int flash);
    apb_write(REG_SCAN_PERIOD, DATA_W'(scan));
    apb_write(REG_REPEAT_PERIOD, DATA_W'(rep));
    apb_write(REG_HOLD_DELAY, DATA_W'(hold));
    apb_write(REG_FLASH_TIME, DATA_W'(flash));
  endtask

  // Mostly held presses with releases between, some single-tick noise.
  task automatic random_phase(input int n_words);
    int sent, span, len, pick, scan, rep;
    bit up, down, pwr;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 20) begin
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        pick = $urandom_range(99);
        up   = (pick < 35) || (pick >= 75 && pick < 85);
        down = (pick >= 35 && pick < 60) || (pick >= 75 && pick < 85);
        pwr  = (pick >= 60 && pick < 75);
        if (pick >= 85) begin
          up   = 1'($urandom_range(1));
          down = 1'($urandom_range(1));
          pwr  = 1'b1;
        end
        scan = (sb.scan_period == 0) ? 1 : int'(sb.scan_period);
        rep  = (sb.repeat_period == 0) ? 1 : int'(sb.repeat_period);
        span = scan + (int'(sb.hold_delay) + 3) * rep;
        if (span > 150) span = 150;
        len = $urandom_range(1, span);
        for (int i = 0; i < len; i++) send_tick(up, down, pwr);
        len = $urandom_range(1, (scan > 20 ? 20 : scan) + 2);
        for (int i = 0; i < len; i++) send_tick(1'b0, 1'b0, 1'b0);
        sent += span;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the first tick scans at once.
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    settle();

    // All registers zero: every period and the flash act as one tick.
    write_config(0, 0, 0, 0);
    send_tick(1'b0, 1'b0, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    // Step down to zero so PWM turns off.
    repeat (4) send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    // Power alone toggles PWM one scan later.
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    // Plus and minus together, then all three.
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    settle();

    // Lower the hold delay under the running hold count while plus stays held.
    apb_write(REG_HOLD_DELAY, DATA_W'(20));
    repeat (6) send_tick(1'b1, 1'b0, 1'b0);
    settle();
    apb_write(REG_HOLD_DELAY, DATA_W'(2));
    repeat (2) send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    settle();

    // Random phases, cycling through the idle modes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_config(1, 1, 0, 1);
        1: write_config(255, 255, 63, 255);
        2: write_config(3, 1, 63, 255);
        default: write_config($urandom_range(0, 6), $urandom_range(0, 4),
                              $urandom_range(0, 8), $urandom_range(0, 12));
      endcase
      src_idle_pct  = (ph % 4 == 1) ? 79 : (ph % 4 == 3) ? 38 : 0;
      snk_stall_pct = (ph % 4 == 2) ? 79 : (ph % 4 == 3) ? 38 : 0;
      // Hold off the result side long enough to back up the input.
      if (ph == 4) holdoff_request = 1'b1;
      random_phase(75);
      settle();
    end

    // Ramp plus with every period at one tick, then play around the result.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_config(0, 0, 0, 2);
    repeat (60) send_tick(1'b1, 1'b0, 1'b0);
    settle();
    write_config($urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 4),
                 $urandom_range(0, 8));
    src_idle_pct  = 38;
    snk_stall_pct = 38;
    random_phase(60);
    settle();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d lamp words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("** button_dimmer_controller: PASSED **");
    end else begin
      $display("** button_dimmer_controller: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("** button_dimmer_controller: FAILED **");
    $finish;
  end

endmodule

>>> button_dimmer_controller.f
+incdir+sv
sv/bdc_pkg.sv
sv/bdc_cfg.sv
sv/bdc_core.sv
sv/button_dimmer_controller.sv
tb/sv/button_dimmer_controller_tb.sv
